FILE: src/assert_macros.svh
// Assertion macros shared by the checker files of this project.
// Needs nothing else; every macro takes its clock and reset as arguments.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: src/bed_pkg.sv
// Shared types and constants of the backslash escape decoder.
// Has no dependencies; used by the decoder and by its checker.
package bed_pkg;

  // Decoder modes.
  localparam logic [1:0] MODE_TEXT = 2'd0;
  localparam logic [1:0] MODE_ESC  = 2'd1;
  localparam logic [1:0] MODE_OCT  = 2'd2;
  localparam logic [1:0] MODE_HEX  = 2'd3;

  // Characters with a meaning to the decoder.
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_C      = 8'h63;
  localparam logic [7:0] CH_O      = 8'h6F;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_F   = 8'h46;

  // Control bytes produced by the single-letter escapes.
  localparam logic [7:0] BYTE_NL   = 8'h0A;
  localparam logic [7:0] BYTE_TAB  = 8'h09;
  localparam logic [7:0] BYTE_BS   = 8'h08;
  localparam logic [7:0] BYTE_CR   = 8'h0D;
  localparam logic [7:0] BYTE_BEL  = 8'h07;
  localparam logic [7:0] BYTE_FF   = 8'h0C;
  localparam logic [7:0] BYTE_VT   = 8'h0B;
  localparam logic [7:0] BYTE_NUL  = 8'h00;

  // Digits per run.
  localparam logic [1:0] OCT_DIGITS = 2'd3;
  localparam logic [1:0] HEX_DIGITS = 2'd2;

  // Depth of the result queue.
  localparam int QUEUE_DEPTH = 3;

  // One result beat.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } res_t;

endpackage

FILE: src/backslash_escape_decoder.sv
// Backslash escape decoder: top level with decode logic and result queue.
// Depends on bed_pkg.
//
// The decoder takes one text byte per beat and expands C-style backslash
// escapes. A byte is taken every cycle as long as each byte gives at most one
// result and the output side takes a beat every cycle; a byte that gives two
// results (an unknown escape, or a digit run closed by a plain byte) needs the
// output port for both, so such bytes cannot be taken every cycle. The rate
// is set by the single output port and the three-entry result queue behind
// it: a new byte is taken whenever at most one result waits. The results of a
// byte are registered in the result queue, behind any result that still waits.
// Every byte that gives results carries tlast on its last result.
module backslash_escape_decoder
  import bed_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // last_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast   // run_end
);

  // Decoder state.
  logic [1:0] mode_r, mode_nxt;
  logic [1:0] dcnt_r, dcnt_nxt;
  logic [7:0] acc_r, acc_nxt;

  // Result queue.
  res_t       q_r [QUEUE_DEPTH];
  res_t       q_nxt [QUEUE_DEPTH];
  logic [1:0] count_r, count_nxt;

  logic       in_acc;
  logic       pop;
  logic [1:0] n_res;
  logic [7:0] res0, res1;

  // Digit classification.
  logic       is_oct, is_dec, is_lhex, is_uhex, is_digit;
  logic [3:0] dval;
  logic [7:0] acc_dig;
  logic [1:0] dcnt_inc;

  assign in_tready  = (count_r <= 2'd1);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = (count_r != 2'd0);
  assign pop        = out_tvalid && out_tready;
  assign out_tdata  = q_r[0].data;
  assign out_tlast  = q_r[0].last;

  // Digit value of the incoming byte in the current radix.
  always_comb begin
    is_oct   = (in_tdata >= CH_ZERO) && (in_tdata <= CH_SEVEN);
    is_dec   = (in_tdata >= CH_ZERO) && (in_tdata <= CH_NINE);
    is_lhex  = (in_tdata >= CH_A) && (in_tdata <= CH_F);
    is_uhex  = (in_tdata >= CH_UC_A) && (in_tdata <= CH_UC_F);
    if (mode_r == MODE_HEX) begin
      is_digit = is_dec || is_lhex || is_uhex;
    end else begin
      is_digit = is_oct;
    end
    if (is_lhex) begin
      dval = 4'(in_tdata - CH_A + 8'd10);
    end else if (is_uhex) begin
      dval = 4'(in_tdata - CH_UC_A + 8'd10);
    end else begin
      dval = 4'(in_tdata - CH_ZERO);
    end
    if (mode_r == MODE_HEX) begin
      acc_dig = {acc_r[3:0], dval};
    end else begin
      acc_dig = {acc_r[4:0], dval[2:0]};
    end
    dcnt_inc = dcnt_r + 2'd1;
  end

  // Decode one byte: next state and up to two results.
  always_comb begin
    mode_nxt = mode_r;
    dcnt_nxt = dcnt_r;
    acc_nxt  = acc_r;
    n_res    = 2'd0;
    res0     = in_tdata;
    res1     = in_tdata;
    unique case (mode_r)
      MODE_TEXT: begin
        if (in_tdata == CH_BSLASH && !in_tlast) begin
          mode_nxt = MODE_ESC;
        end else begin
          n_res = 2'd1;
        end
      end
      MODE_ESC: begin
        mode_nxt = MODE_TEXT;
        n_res    = 2'd1;
        unique case (in_tdata)
          CH_N:      res0 = BYTE_NL;
          CH_T:      res0 = BYTE_TAB;
          CH_B:      res0 = BYTE_BS;
          CH_R:      res0 = BYTE_CR;
          CH_A:      res0 = BYTE_BEL;
          CH_F:      res0 = BYTE_FF;
          CH_V:      res0 = BYTE_VT;
          CH_BSLASH, CH_SQUOTE, CH_DQUOTE, CH_QMARK: res0 = in_tdata;
          CH_ZERO:   res0 = BYTE_NUL;
          CH_C:      n_res = 2'd0;
          CH_O, CH_X: begin
            dcnt_nxt = 2'd0;
            acc_nxt  = 8'd0;
            res0     = BYTE_NUL;
            if (!in_tlast) begin
              n_res    = 2'd0;
              mode_nxt = (in_tdata == CH_O) ? MODE_OCT : MODE_HEX;
            end
          end
          default: begin
            n_res = 2'd2;
            res0  = CH_BSLASH;
            res1  = in_tdata;
          end
        endcase
      end
      MODE_OCT, MODE_HEX: begin
        if (is_digit) begin
          acc_nxt  = acc_dig;
          dcnt_nxt = dcnt_inc;
          res0     = acc_dig;
          if (in_tlast || dcnt_inc >= ((mode_r == MODE_HEX) ? HEX_DIGITS : OCT_DIGITS)) begin
            n_res    = 2'd1;
            mode_nxt = MODE_TEXT;
            dcnt_nxt = 2'd0;
            acc_nxt  = 8'd0;
          end
        end else begin
          // The run is closed; the byte is then handled as in text mode.
          res0     = acc_r;
          mode_nxt = MODE_TEXT;
          dcnt_nxt = 2'd0;
          acc_nxt  = 8'd0;
          if (in_tdata == CH_BSLASH && !in_tlast) begin
            n_res    = 2'd1;
            mode_nxt = MODE_ESC;
          end else begin
            n_res = 2'd2;
          end
        end
      end
      default: begin
        mode_nxt = MODE_TEXT;
      end
    endcase
  end

  // Queue update: drop the head on a pop, then append the new results.
  always_comb begin
    logic [1:0] base;
    base      = pop ? (count_r - 2'd1) : count_r;
    q_nxt     = q_r;
    count_nxt = base;
    if (pop) begin
      q_nxt[0] = q_r[1];
      q_nxt[1] = q_r[2];
    end
    if (in_acc && n_res != 2'd0) begin
      q_nxt[base] = '{data: res0, last: (n_res == 2'd1)};
      if (n_res == 2'd2) begin
        q_nxt[2'(base + 2'd1)] = '{data: res1, last: 1'b1};
      end
      count_nxt = 2'(base + n_res);
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_TEXT;
      dcnt_r  <= 2'd0;
      acc_r   <= 8'd0;
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (in_acc) begin
        mode_r <= mode_nxt;
        dcnt_r <= dcnt_nxt;
        acc_r  <= acc_nxt;
      end
    end
  end

  // Queue payload.
  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

endmodule

FILE: src/bed_checker.sv
// Port-level checker for the backslash escape decoder, bound to the top level.
// Depends on bed_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bed_checker
  import bed_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // A stalled result beat holds its value.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast))

  // Back-pressure on the input only comes from results that are waiting.
  `ASSERT_SAME(a_stall_has_data, clk, rst_n, !in_tready, out_tvalid)

  // A last byte always gives a result, except the empty escape.
  `ASSERT_NEXT(a_last_emits, clk, rst_n, in_tvalid && in_tready && in_tlast && in_tdata != CH_C, out_tvalid)

endmodule

bind backslash_escape_decoder bed_checker u_bed_checker (.*);
